// ===== sv/tccs_pkg.sv =====
// types, constants and cursor step function for the text console cursor unit
package tccs_pkg;

  localparam int unsigned CharW    = 8;
  localparam int unsigned PosW     = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned MaxRes   = 4;
  localparam int unsigned ResCntW  = 3;

  localparam logic [PosW-1:0] MaxColumns = 8'd255;
  localparam logic [PosW-1:0] MaxRows    = 8'd255;

  localparam logic [CharW-1:0] ChTab     = 8'd9;
  localparam logic [CharW-1:0] ChNewline = 8'd10;
  localparam logic [CharW-1:0] ChSpace   = 8'd32;

  localparam logic [PosW-1:0] ResetColumns = 8'd80;
  localparam logic [PosW-1:0] ResetRows    = 8'd25;

  typedef enum logic [CfgIdxW-1:0] {
    RegEnable  = 2'd0,
    RegColumns = 2'd1,
    RegRows    = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    KindDraw   = 1'b0,
    KindScroll = 1'b1
  } res_kind_e;

  typedef struct packed {
    res_kind_e        kind;
    logic [PosW-1:0]  col;
    logic [PosW-1:0]  row;
    logic [CharW-1:0] glyph;
    logic             last;
  } res_t;

  // outcome of one non-tab character
  typedef struct packed {
    logic            draw;
    logic            scroll;
    logic [PosW-1:0] col;
    logic [PosW-1:0] row;
  } step_t;

  // zero counts as one, oversize saturates
  function automatic logic [PosW-1:0] eff_limit(logic [PosW-1:0] v, logic [PosW-1:0] maxv);
    logic [PosW-1:0] r;
    if (v == '0) begin
      r = PosW'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic step_t one_char(logic [CharW-1:0] c, logic [PosW-1:0] col,
                                     logic [PosW-1:0] row, logic [PosW-1:0] ncol,
                                     logic [PosW-1:0] nrow);
    step_t        s;
    logic [PosW:0] c9;
    logic [PosW:0] r9;
    s.draw = (c != ChNewline);
    c9 = {1'b0, col};
    r9 = {1'b0, row};
    if (!s.draw) begin
      r9 = r9 + (PosW+1)'(1);
      c9 = '0;
    end else begin
      c9 = c9 + (PosW+1)'(1);
      if (c9 >= {1'b0, ncol}) begin
        c9 = '0;
        r9 = r9 + (PosW+1)'(1);
      end
    end
    s.scroll = (r9 >= {1'b0, nrow});
    if (s.scroll) begin
      r9 = {1'b0, nrow} - (PosW+1)'(1);
      c9 = '0;
    end
    s.col = c9[PosW-1:0];
    s.row = r9[PosW-1:0];
    return s;
  endfunction

endpackage

// ===== sv/text_console_cursor_scroll_unit.sv =====
// top level of the text console cursor and scroll unit
// A character word is taken into an input register; once the result queue is free, one pass of
// logic works out every command it causes (a draw and a possible scroll, twice for a tab)
// together with the new cursor, and loads them into a four-entry result queue that drains
// one command word per cycle while the output is ready. A new character is taken while the
// queue still drains; the queue is reloaded in the cycle its last word leaves, and a
// character causes at most four commands (a tab that scrolls twice), so the drain of the
// result queue sets the sustained rate. A disabled unit, or a newline that does not
// scroll, swallows the character and gives nothing. Configuration writes take effect at
// once and should only be made while the unit is idle.
module text_console_cursor_scroll_unit
  import tccs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // character input
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [CharW-1:0]    char_code_i,
  // command output
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                kind_o,
  output logic [PosW-1:0]     cell_column_o,
  output logic [PosW-1:0]     cell_row_o,
  output logic [CharW-1:0]    glyph_code_o,
  output logic                last_o
);

  // configuration registers
  logic            enable_q;
  logic [PosW-1:0] columns_q, rows_q;

  // cursor
  logic [PosW-1:0] cur_col_q, cur_col_d;
  logic [PosW-1:0] cur_row_q, cur_row_d;

  // input register
  logic             in_vld_q, in_vld_d;
  logic [CharW-1:0] char_q;

  // result queue, entry 0 is on the output
  res_t              res_q [MaxRes];
  res_t              res_d [MaxRes];
  logic [ResCntW-1:0] rem_q, rem_d;

  logic in_acc, out_acc, queue_free, proc;

  // geometry and per-character outcomes
  logic [PosW-1:0] ncol, nrow;
  logic            is_tab;
  logic [CharW-1:0] glyph;
  step_t           s0, s1;
  res_t            cand [MaxRes];
  logic [MaxRes-1:0] cand_v;
  res_t            list [MaxRes];
  logic [ResCntW-1:0] n_res;
  logic [ResCntW-1:0] last_idx;

  assign out_valid_o = (rem_q != '0);
  assign out_acc     = out_valid_o && out_ready_i;
  // queue can take a new batch when empty or when its final word leaves now
  assign queue_free  = (rem_q == '0) || ((rem_q == ResCntW'(1)) && out_ready_i);
  assign proc        = in_vld_q && queue_free;
  assign in_ready_o  = !in_vld_q || proc;
  assign in_acc      = in_valid_i && in_ready_o;

  assign kind_o        = res_q[0].kind;
  assign cell_column_o = res_q[0].col;
  assign cell_row_o    = res_q[0].row;
  assign glyph_code_o  = res_q[0].glyph;
  assign last_o        = res_q[0].last;

  // one pass over the held character
  always_comb begin
    ncol   = eff_limit(columns_q, MaxColumns);
    nrow   = eff_limit(rows_q, MaxRows);
    is_tab = (char_q == ChTab);
    glyph  = is_tab ? ChSpace : char_q;
    s0     = one_char(glyph, cur_col_q, cur_row_q, ncol, nrow);
    s1     = one_char(ChSpace, s0.col, s0.row, ncol, nrow);

    cand[0] = '{kind: KindDraw, col: cur_col_q, row: cur_row_q, glyph: glyph, last: 1'b0};
    cand[1] = '{kind: KindScroll, col: '0, row: '0, glyph: '0, last: 1'b0};
    cand[2] = '{kind: KindDraw, col: s0.col, row: s0.row, glyph: ChSpace, last: 1'b0};
    cand[3] = '{kind: KindScroll, col: '0, row: '0, glyph: '0, last: 1'b0};
    cand_v  = {is_tab && s1.scroll, is_tab, s0.scroll, s0.draw};
    if (!enable_q) begin
      cand_v = '0;
    end

    // pack the present commands in order
    n_res = '0;
    for (int i = 0; i < MaxRes; i++) begin
      list[i] = cand[i];
    end
    for (int i = 0; i < MaxRes; i++) begin
      if (cand_v[i]) begin
        list[n_res[ResCntW-2:0]] = cand[i];
        n_res = n_res + ResCntW'(1);
      end
    end
    last_idx = n_res - ResCntW'(1);
    if (n_res != '0) begin
      list[last_idx[ResCntW-2:0]].last = 1'b1;
    end
  end

  // next state of cursor, queue and input register
  always_comb begin
    cur_col_d = cur_col_q;
    cur_row_d = cur_row_q;
    rem_d     = rem_q;
    for (int i = 0; i < MaxRes; i++) begin
      res_d[i] = res_q[i];
    end
    in_vld_d = in_vld_q;

    if (proc) begin
      if (enable_q) begin
        cur_col_d = is_tab ? s1.col : s0.col;
        cur_row_d = is_tab ? s1.row : s0.row;
      end
      for (int i = 0; i < MaxRes; i++) begin
        res_d[i] = list[i];
      end
      rem_d = n_res;
    end else if (out_acc) begin
      // shift the queue down by one word
      for (int i = 0; i < MaxRes - 1; i++) begin
        res_d[i] = res_q[i+1];
      end
      rem_d = rem_q - ResCntW'(1);
    end

    if (in_acc) begin
      in_vld_d = 1'b1;
    end else if (proc) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q  <= 1'b0;
      columns_q <= ResetColumns;
      rows_q    <= ResetRows;
      cur_col_q <= '0;
      cur_row_q <= '0;
      in_vld_q  <= 1'b0;
      rem_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegEnable:  enable_q  <= cfg_data_i[0];
          RegColumns: columns_q <= cfg_data_i;
          RegRows:    rows_q    <= cfg_data_i;
          default:    ;
        endcase
      end
      cur_col_q <= cur_col_d;
      cur_row_q <= cur_row_d;
      in_vld_q  <= in_vld_d;
      rem_q     <= rem_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      char_q <= char_code_i;
    end
    for (int i = 0; i < MaxRes; i++) begin
      res_q[i] <= res_d[i];
    end
  end

endmodule

// ===== sv/tccs_checker.sv =====
// port-level checker for the text console cursor unit, with its bind
module tccs_checker
  import tccs_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic             kind_o,
  input logic [PosW-1:0]  cell_column_o,
  input logic [PosW-1:0]  cell_row_o,
  input logic [CharW-1:0] glyph_code_o,
  input logic             last_o
);

  // a stalled word stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  // scroll words carry no cell or glyph
  a_scroll_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KindScroll |->
      cell_column_o == '0 && cell_row_o == '0 && glyph_code_o == '0)
    else $error("scroll word with nonzero cell or glyph");

  // words of one character come without a gap
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=> out_valid_o)
    else $error("gap inside the words of one character");

  // a scroll mid tab is followed by a space drawn at column zero
  a_after_scroll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o && kind_o == KindScroll |=>
      kind_o == KindDraw && cell_column_o == '0 && glyph_code_o == ChSpace)
    else $error("tab scroll not followed by draw at column zero");

  // a draw that is not last is followed by scroll or a second space of a tab
  a_draw_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o && kind_o == KindDraw |=>
      kind_o == KindScroll || glyph_code_o == ChSpace)
    else $error("unexpected word after a non-final draw");

endmodule

bind text_console_cursor_scroll_unit tccs_checker u_tccs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .kind_o        (kind_o),
  .cell_column_o (cell_column_o),
  .cell_row_o    (cell_row_o),
  .glyph_code_o  (glyph_code_o),
  .last_o        (last_o)
);

// ===== tb/tb_text_console_cursor_scroll_unit.sv =====
// self-checking testbench for the text console cursor and scroll unit
`timescale 1ns / 1ps

module tb_text_console_cursor_scroll_unit;
  import tccs_pkg::*;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [CharW-1:0]    char_code_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic                kind_o;
  logic [PosW-1:0]     cell_column_o;
  logic [PosW-1:0]     cell_row_o;
  logic [CharW-1:0]    glyph_code_o;
  logic                last_o;

  text_console_cursor_scroll_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .char_code_i  (char_code_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .cell_column_o(cell_column_o),
    .cell_row_o   (cell_row_o),
    .glyph_code_o (glyph_code_o),
    .last_o       (last_o)
  );

  // directed plan: a row is either a character word or a register write
  typedef enum logic {RowChar, RowWrite} row_op_e;
  // how a character row is checked: by the cursor tracker, no command, or one typed command
  typedef enum logic [1:0] {ExpTracked, ExpNone, ExpTyped} row_check_e;

  typedef struct packed {
    row_op_e    op;
    cfg_reg_e   sel;
    logic [7:0] val;
    row_check_e chk;
    res_t       cmd;
  } plan_row_t;

  localparam int PlanLen = 31;
  localparam int SettleCycles = 8;

  plan_row_t plan [PlanLen] = '{
    // disabled after reset: nothing comes out
    '{RowChar,  RegEnable,  8'd65,  ExpNone,    '0},
    '{RowWrite, RegEnable,  8'd1,   ExpTracked, '0},
    // plain draws on the reset geometry, cursor walks along row 0
    '{RowChar,  RegEnable,  8'd65,  ExpTyped,   '{KindDraw, 8'd0, 8'd0, 8'd65,  1'b1}},
    '{RowChar,  RegEnable,  8'd0,   ExpTyped,   '{KindDraw, 8'd1, 8'd0, 8'd0,   1'b1}},
    '{RowChar,  RegEnable,  8'd255, ExpTyped,   '{KindDraw, 8'd2, 8'd0, 8'd255, 1'b1}},
    // newline far from the bottom only moves the cursor
    '{RowChar,  RegEnable,  8'd10,  ExpNone,    '0},
    '{RowChar,  RegEnable,  8'd9,   ExpTracked, '0},
    '{RowChar,  RegEnable,  8'h7f,  ExpTracked, '0},
    // one by one screen with the cursor left outside it
    '{RowWrite, RegColumns, 8'd1,   ExpTracked, '0},
    '{RowWrite, RegRows,    8'd1,   ExpTracked, '0},
    '{RowChar,  RegEnable,  8'h78,  ExpTracked, '0},
    '{RowChar,  RegEnable,  8'd9,   ExpTracked, '0},
    '{RowChar,  RegEnable,  8'd10,  ExpTracked, '0},
    // zero geometry counts as one
    '{RowWrite, RegColumns, 8'd0,   ExpTracked, '0},
    '{RowWrite, RegRows,    8'd0,   ExpTracked, '0},
    '{RowChar,  RegEnable,  8'h55,  ExpTracked, '0},
    '{RowChar,  RegEnable,  8'haa,  ExpTracked, '0},
    // widest screen
    '{RowWrite, RegColumns, 8'd255, ExpTracked, '0},
    '{RowWrite, RegRows,    8'd255, ExpTracked, '0},
    '{RowChar,  RegEnable,  8'd10,  ExpTracked, '0},
    '{RowChar,  RegEnable,  8'd9,   ExpTracked, '0},
    '{RowChar,  RegEnable,  8'h01,  ExpTracked, '0},
    // shrink the rows under the cursor, then a newline scrolls
    '{RowWrite, RegRows,    8'd2,   ExpTracked, '0},
    '{RowChar,  RegEnable,  8'd10,  ExpTracked, '0},
    '{RowWrite, RegColumns, 8'd3,   ExpTracked, '0},
    '{RowChar,  RegEnable,  8'd9,   ExpTracked, '0},
    '{RowChar,  RegEnable,  8'h41,  ExpTracked, '0},
    // disabled mid-run: a tab is swallowed and the cursor holds
    '{RowWrite, RegEnable,  8'd0,   ExpTracked, '0},
    '{RowChar,  RegEnable,  8'd9,   ExpNone,    '0},
    '{RowWrite, RegEnable,  8'd1,   ExpTracked, '0},
    '{RowChar,  RegEnable,  8'd10,  ExpTracked, '0}
  };

  // tracker copy of the unit's registers and cursor
  logic       en_q;
  logic [7:0] cols_q;
  logic [7:0] rows_q;
  logic [7:0] cur_col;
  logic [7:0] cur_row;

  res_t pending_cmds[$];   // commands still owed by the unit, oldest first
  res_t char_cmds[$];      // commands of the character being tracked
  int   mismatches;
  bit   calm;              // no idling on either side while set

  // draw or newline for one non-tab byte, followed by the bottom-row check
  function automatic void place_byte(logic [7:0] c);
    logic [8:0] c9;
    logic [8:0] r9;
    logic [8:0] ncol;
    logic [8:0] nrow;
    // registers are 8 bits, so only the zero case needs fixing up
    ncol = (cols_q == 8'd0) ? 9'd1 : {1'b0, cols_q};
    nrow = (rows_q == 8'd0) ? 9'd1 : {1'b0, rows_q};
    c9 = {1'b0, cur_col};
    r9 = {1'b0, cur_row};
    if (c == ChNewline) begin
      r9 = r9 + 9'd1;
      c9 = '0;
    end else begin
      char_cmds.push_back('{kind: KindDraw, col: cur_col, row: cur_row, glyph: c, last: 1'b0});
      c9 = c9 + 9'd1;
      if (c9 >= ncol) begin
        c9 = '0;
        r9 = r9 + 9'd1;
      end
    end
    if (r9 >= nrow) begin
      r9 = nrow - 9'd1;
      c9 = '0;
      char_cmds.push_back('{kind: KindScroll, col: 8'd0, row: 8'd0, glyph: 8'd0, last: 1'b0});
    end
    cur_col = c9[7:0];
    cur_row = r9[7:0];
  endfunction

  // fills char_cmds with the commands one character word causes
  function automatic void track_char(logic [7:0] ch);
    char_cmds.delete();
    if (en_q) begin
      if (ch == ChTab) begin
        place_byte(ChSpace);
        place_byte(ChSpace);
      end else begin
        place_byte(ch);
      end
      if (char_cmds.size() > 0) char_cmds[char_cmds.size()-1].last = 1'b1;
    end
  endfunction

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // overall limit, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // command side back-pressure, changed on the falling edge
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i <= calm || ($urandom_range(0, 99) >= 17);
    end
  end

  // command checker: every accepted word against the oldest owed command
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected command: kind %0d col %0d row %0d glyph %0d last %0d",
                   kind_o, cell_column_o, cell_row_o, glyph_code_o, last_o);
      end else begin
        want = pending_cmds.pop_front();
        if (kind_o !== want.kind || cell_column_o !== want.col || cell_row_o !== want.row ||
            glyph_code_o !== want.glyph || last_o !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"command mismatch: want kind %0d col %0d row %0d glyph %0d last %0d,",
                      " got kind %0d col %0d row %0d glyph %0d last %0d"},
                     want.kind, want.col, want.row, want.glyph, want.last,
                     kind_o, cell_column_o, cell_row_o, glyph_code_o, last_o);
        end
      end
    end
  end

  // one character word: random hold-off, then hold valid until taken
  task automatic send_char(input logic [7:0] ch, input row_check_e chk, input res_t typed);
    while (!calm && $urandom_range(0, 99) < 17) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= ch;
    do @(posedge clk_i); while (!in_ready_o);
    track_char(ch);
    if (chk == ExpTyped) pending_cmds.push_back(typed);
    else if (chk == ExpTracked) foreach (char_cmds[k]) pending_cmds.push_back(char_cmds[k]);
    @(negedge clk_i);
  endtask

  // unit idle: nothing owed, then a settling wait of SettleCycles for a swallowed character
  task automatic drain_commands();
    in_valid_i <= 1'b0;
    while (pending_cmds.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e sel, input logic [7:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= sel;
    cfg_data_i <= val;
    case (sel)
      RegEnable:  en_q   = val[0];
      RegColumns: cols_q = val;
      RegRows:    rows_q = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] pick_geometry(int top);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'd255;
    if (r == 2) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(1, top));
  endfunction

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return ChNewline;
    if (r < 35) return ChTab;
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin
    int phase;
    int taken;
    int n;
    logic en;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = RegEnable;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    char_code_i = '0;
    calm        = 1'b0;
    mismatches  = 0;
    en_q        = 1'b0;
    cols_q      = ResetColumns;
    rows_q      = ResetRows;
    cur_col     = '0;
    cur_row     = '0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed plan
    foreach (plan[i]) begin
      if (plan[i].op == RowWrite) begin
        drain_commands();
        write_reg(plan[i].sel, plan[i].val);
      end else begin
        send_char(plan[i].val, plan[i].chk, plan[i].cmd);
      end
    end

    // random phases, each on a fresh setting written while idle; the
    // idle wait before each phase also gives the sender's full pause
    phase = 0;
    taken = 0;
    while (taken < 150) begin
      drain_commands();
      calm = (phase == 2 || phase == 3);
      en = (phase == 0) || ($urandom_range(0, 7) != 0);
      write_reg(RegEnable, {7'd0, en});
      write_reg(RegColumns, pick_geometry(12));
      write_reg(RegRows, pick_geometry(6));
      n = en ? $urandom_range(12, 30) : 6;
      repeat (n) send_char(pick_char(), ExpTracked, '0);
      if (en) taken += n;
      phase++;
    end

    calm = 1'b0;
    drain_commands();
    repeat (20) @(negedge clk_i);
    if (mismatches == 0 && pending_cmds.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
